[rtl/core/cpt_pkg.sv]
package cpt_pkg;

  // region codes reported on out_region
  localparam logic [2:0] RGN_A  = 3'd0;
  localparam logic [2:0] RGN_B  = 3'd1;
  localparam logic [2:0] RGN_C  = 3'd2;
  localparam logic [2:0] RGN_AB = 3'd3;
  localparam logic [2:0] RGN_AC = 3'd4;
  localparam logic [2:0] RGN_BC = 3'd5;
  localparam logic [2:0] RGN_IN = 3'd6;

  // operand slice handled by one multiplier step
  localparam int MUL_CHUNK = 32;

endpackage

[rtl/core/cpt_mul.sv]
module cpt_mul import cpt_pkg::*; #(
  parameter int AW = 33,
  parameter int BW = 137
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] op_a,
  input  logic signed [BW-1:0] op_b,
  output logic signed [AW+BW-1:0] prod
);

  localparam int NCH = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int BPW = NCH * MUL_CHUNK;
  localparam int NCA = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int APW = NCA * MUL_CHUNK;
  localparam int PW  = AW + BW;

  logic [APW-1:0] am_r  [NCH];
  logic [BPW-1:0] bm_r  [NCH];
  logic           sg_r  [NCH+1];
  logic [PW-1:0]  acc_r [NCH+1];
  logic [AW-1:0]  amag;
  logic [BW-1:0]  bmag;

  assign amag = op_a[AW-1] ? -op_a : op_a;
  assign bmag = op_b[BW-1] ? -op_b : op_b;

  // magnitudes and sign
  always_ff @(posedge clk) begin
    am_r[0]  <= APW'(amag);
    bm_r[0]  <= BPW'(bmag);
    sg_r[0]  <= op_a[AW-1] ^ op_b[BW-1];
    acc_r[0] <= '0;
  end

  // one chunk of B per stage, A split into chunk-sized partial products
  for (genvar i = 1; i <= NCH; i++) begin : g_step
    logic [2*MUL_CHUNK-1:0]  pc [NCA];
    logic [AW+MUL_CHUNK-1:0] pp;
    for (genvar j = 0; j < NCA; j++) begin : g_part
      assign pc[j] = am_r[i-1][j*MUL_CHUNK +: MUL_CHUNK]
                   * bm_r[i-1][(i-1)*MUL_CHUNK +: MUL_CHUNK];
    end
    always_comb begin
      pp = '0;
      for (int j = 0; j < NCA; j++) begin
        pp = pp + ((AW+MUL_CHUNK)'(pc[j]) << (j * MUL_CHUNK));
      end
    end
    always_ff @(posedge clk) begin
      acc_r[i] <= acc_r[i-1] + (PW'(pp) << ((i-1) * MUL_CHUNK));
      sg_r[i]  <= sg_r[i-1];
    end
    if (i < NCH) begin : g_pass
      always_ff @(posedge clk) begin
        am_r[i] <= am_r[i-1];
        bm_r[i] <= bm_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= sg_r[NCH] ? -acc_r[NCH] : acc_r[NCH];
  end

endmodule

[rtl/core/cpt_div.sv]
module cpt_div #(
  parameter int NW  = 171,
  parameter int DNW = 139,
  parameter int QB  = 33
) (
  input  logic                  clk,
  input  logic signed [NW-1:0]  num,
  input  logic signed [DNW-1:0] den,
  output logic signed [QB:0]    quo
);

  localparam int CW = (NW > DNW + QB) ? NW : DNW + QB;

  logic [NW-1:0]  nm_r;
  logic [DNW-1:0] dm_r;
  logic           ng0_r;

  logic [CW-1:0]  rem_r [QB+1];
  logic [DNW-1:0] dv_r  [QB+1];
  logic [QB-1:0]  q_r   [QB+1];
  logic           ov_r  [QB+1];
  logic           ng_r  [QB+1];

  always_ff @(posedge clk) begin
    nm_r  <= num[NW-1] ? -num : num;
    dm_r  <= den[DNW-1] ? -den : den;
    ng0_r <= num[NW-1] ^ den[DNW-1];
  end

  // quotient wider than QB bits: clamp, the sum saturates anyway
  always_ff @(posedge clk) begin
    rem_r[0] <= CW'(nm_r);
    dv_r[0]  <= dm_r;
    ov_r[0]  <= CW'(nm_r) >= (CW'(dm_r) << QB);
    ng_r[0]  <= ng0_r;
    q_r[0]   <= '0;
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar s = 0; s < QB; s++) begin : g_bit
    localparam int K = QB - 1 - s;
    logic [CW:0] df;
    assign df = {1'b0, rem_r[s]} - ({1'b0, CW'(dv_r[s])} << K);
    always_ff @(posedge clk) begin
      rem_r[s+1] <= df[CW] ? rem_r[s] : df[CW-1:0];
      q_r[s+1]   <= {q_r[s][QB-2:0], ~df[CW]};
      dv_r[s+1]  <= dv_r[s];
      ov_r[s+1]  <= ov_r[s];
      ng_r[s+1]  <= ng_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (ov_r[QB]) begin
      quo <= ng_r[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
    end else if (ng_r[QB]) begin
      quo <= -((QB+1)'(q_r[QB]));
    end else begin
      quo <= (QB+1)'(q_r[QB]);
    end
  end

endmodule

[rtl/core/closest_point_on_triangle_core.sv]
// Closest point of a triangle (vertices A, B, C, signed fixed point) to the
// origin, with the Voronoi region that holds it (vertex A, B, C, edge AB,
// AC, BC, interior, tested in that order) and a degenerate flag that is set,
// with A returned, when the selected edge or interior divisor is zero.
// Fully pipelined: one triangle per clock, busy is always low, and each
// result appears on out_* with out_valid high for exactly one cycle. There
// is no output backpressure: the receiver cannot stall and must take each
// result in its strobe cycle. The datapath is built from two chunked
// multiplier pipelines (32 bits of one operand per stage) and a restoring
// divider that resolves one quotient bit per stage (COORD_BITS+1 stages).
// Coordinates saturate to the signed COORD_BITS range. The binary point
// position does not matter: all ratios are scale-free.
module closest_point_on_triangle_core import cpt_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_a_x,
  input  logic signed [COORD_BITS-1:0] in_a_y,
  input  logic signed [COORD_BITS-1:0] in_a_z,
  input  logic signed [COORD_BITS-1:0] in_b_x,
  input  logic signed [COORD_BITS-1:0] in_b_y,
  input  logic signed [COORD_BITS-1:0] in_b_z,
  input  logic signed [COORD_BITS-1:0] in_c_x,
  input  logic signed [COORD_BITS-1:0] in_c_y,
  input  logic signed [COORD_BITS-1:0] in_c_z,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] out_near_x,
  output logic signed [COORD_BITS-1:0] out_near_y,
  output logic signed [COORD_BITS-1:0] out_near_z,
  output logic [2:0]                   out_region,
  output logic                         out_degenerate
);

  // datapath widths, all exact
  localparam int W    = COORD_BITS;
  localparam int EW   = W + 1;        // edge vectors
  localparam int PW   = 2 * W + 1;    // edge * vertex products
  localparam int DW   = 2 * W + 4;    // d1..d6
  localparam int EDW  = DW + 2;       // d differences
  localparam int VW   = 2 * DW + 1;   // va, vb, vc
  localparam int DENW = VW + 2;       // divisor
  localparam int MW2  = EW + VW;      // numerator products
  localparam int NW   = MW2 + 1;      // numerator
  localparam int QB   = W + 1;        // quotient magnitude bits
  localparam int SW   = W + 3;        // base + quotient
  localparam int LM1  = (DW + MUL_CHUNK - 1) / MUL_CHUNK + 2;
  localparam int LM2  = (VW + MUL_CHUNK - 1) / MUL_CHUNK + 2;
  localparam int LDV  = QB + 3;
  localparam int LATENCY = LM1 + LM2 + LDV + 8;

  typedef struct packed {
    logic [2:0][W-1:0]  a, b, c;
    logic [2:0][EW-1:0] ab, ac, bc;
  } geo_t;

  typedef struct packed {
    geo_t              g;
    logic [5:0][DW-1:0] d;
  } side1_t;

  typedef struct packed {
    logic [2:0]         rg;
    logic [DENW-1:0]    den;
    logic [2:0][W-1:0]  base, a;
  } side2_t;

  typedef struct packed {
    logic [2:0]         rg;
    logic               deg;
    logic [2:0][W-1:0]  base, a;
  } side3_t;

  // never stalls
  assign busy = 1'b0;

  // ---------------- stage 1: capture the transaction
  logic                v1_r;
  logic signed [W-1:0] a1_r [3];
  logic signed [W-1:0] b1_r [3];
  logic signed [W-1:0] c1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a1_r[0] <= in_a_x; a1_r[1] <= in_a_y; a1_r[2] <= in_a_z;
    b1_r[0] <= in_b_x; b1_r[1] <= in_b_y; b1_r[2] <= in_b_z;
    c1_r[0] <= in_c_x; c1_r[1] <= in_c_y; c1_r[2] <= in_c_z;
  end

  // ---------------- stage 2: edge vectors
  logic v2_r, v3_r, v4_r;
  geo_t geo2_nxt, geo2_r, geo3_r, geo4_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      geo2_nxt.a[k]  = a1_r[k];
      geo2_nxt.b[k]  = b1_r[k];
      geo2_nxt.c[k]  = c1_r[k];
      geo2_nxt.ab[k] = EW'(b1_r[k]) - EW'(a1_r[k]);
      geo2_nxt.ac[k] = EW'(c1_r[k]) - EW'(a1_r[k]);
      geo2_nxt.bc[k] = EW'(c1_r[k]) - EW'(b1_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    geo2_r <= geo2_nxt;
    geo3_r <= geo2_r;
    geo4_r <= geo3_r;
  end

  // ---------------- stage 3: per-axis products for the six dots
  // order: ab.a, ac.a, ab.b, ac.b, ab.c, ac.c
  logic signed [PW-1:0] pr3_r [6][3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pr3_r[0][k] <= $signed(geo2_r.ab[k]) * $signed(geo2_r.a[k]);
      pr3_r[1][k] <= $signed(geo2_r.ac[k]) * $signed(geo2_r.a[k]);
      pr3_r[2][k] <= $signed(geo2_r.ab[k]) * $signed(geo2_r.b[k]);
      pr3_r[3][k] <= $signed(geo2_r.ac[k]) * $signed(geo2_r.b[k]);
      pr3_r[4][k] <= $signed(geo2_r.ab[k]) * $signed(geo2_r.c[k]);
      pr3_r[5][k] <= $signed(geo2_r.ac[k]) * $signed(geo2_r.c[k]);
    end
  end

  // ---------------- stage 4: d1..d6, vectors to origin are negated vertices
  logic signed [DW-1:0] d4_r [6];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 6; j++) begin
      d4_r[j] <= -(DW'(pr3_r[j][0]) + DW'(pr3_r[j][1]) + DW'(pr3_r[j][2]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // ---------------- region determinants: six pipelined products
  // vc = d1*d4 - d3*d2, vb = d5*d2 - d1*d6, va = d3*d6 - d5*d4
  logic signed [2*DW-1:0] mp [6];

  cpt_mul #(.AW(DW), .BW(DW)) u_m0 (.clk(clk), .op_a(d4_r[0]), .op_b(d4_r[3]), .prod(mp[0]));
  cpt_mul #(.AW(DW), .BW(DW)) u_m1 (.clk(clk), .op_a(d4_r[2]), .op_b(d4_r[1]), .prod(mp[1]));
  cpt_mul #(.AW(DW), .BW(DW)) u_m2 (.clk(clk), .op_a(d4_r[4]), .op_b(d4_r[1]), .prod(mp[2]));
  cpt_mul #(.AW(DW), .BW(DW)) u_m3 (.clk(clk), .op_a(d4_r[0]), .op_b(d4_r[5]), .prod(mp[3]));
  cpt_mul #(.AW(DW), .BW(DW)) u_m4 (.clk(clk), .op_a(d4_r[2]), .op_b(d4_r[5]), .prod(mp[4]));
  cpt_mul #(.AW(DW), .BW(DW)) u_m5 (.clk(clk), .op_a(d4_r[4]), .op_b(d4_r[3]), .prod(mp[5]));

  side1_t         dl1_r [LM1];
  logic [LM1-1:0] vl1_r;
  side1_t         s1_in;

  always_comb begin
    s1_in.g = geo4_r;
    for (int j = 0; j < 6; j++) begin
      s1_in.d[j] = d4_r[j];
    end
  end

  always_ff @(posedge clk) begin
    dl1_r[0] <= s1_in;
    for (int i = 1; i < LM1; i++) begin
      dl1_r[i] <= dl1_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl1_r <= '0;
    end else begin
      vl1_r <= {vl1_r[LM1-2:0], v4_r};
    end
  end

  // ---------------- stage 6: determinants and d differences
  logic                  v6_r;
  geo_t                  geo6_r;
  logic signed [DW-1:0]  dd_r [6];
  logic signed [VW-1:0]  va6_r, vb6_r, vc6_r;
  logic signed [EDW-1:0] e1_r, e2_r, e3_r, e4_r, e5_r;
  side1_t                s5;

  assign s5 = dl1_r[LM1-1];

  always_ff @(posedge clk) begin
    geo6_r <= s5.g;
    for (int j = 0; j < 6; j++) begin
      dd_r[j] <= s5.d[j];
    end
    vc6_r <= VW'(mp[0]) - VW'(mp[1]);
    vb6_r <= VW'(mp[2]) - VW'(mp[3]);
    va6_r <= VW'(mp[4]) - VW'(mp[5]);
    e1_r  <= EDW'($signed(s5.d[3])) - EDW'($signed(s5.d[2]));   // d4 - d3
    e2_r  <= EDW'($signed(s5.d[4])) - EDW'($signed(s5.d[5]));   // d5 - d6
    e3_r  <= EDW'($signed(s5.d[0])) - EDW'($signed(s5.d[2]));   // d1 - d3
    e4_r  <= EDW'($signed(s5.d[1])) - EDW'($signed(s5.d[5]));   // d2 - d6
    e5_r  <= EDW'($signed(s5.d[3])) - EDW'($signed(s5.d[2]))
           + EDW'($signed(s5.d[4])) - EDW'($signed(s5.d[5]));
  end

  // ---------------- stage 7: region test and operand select
  logic [2:0]             rg_nxt;
  logic signed [DENW-1:0] den_nxt;
  logic signed [VW-1:0]   x1_nxt, x2_nxt;
  logic signed [EW-1:0]   y1_nxt [3];
  logic signed [EW-1:0]   y2_nxt [3];
  logic signed [W-1:0]    base_nxt [3];

  always_comb begin
    rg_nxt  = RGN_IN;
    den_nxt = DENW'(va6_r) + DENW'(vb6_r) + DENW'(vc6_r);
    x1_nxt  = vb6_r;
    x2_nxt  = vc6_r;
    for (int k = 0; k < 3; k++) begin
      y1_nxt[k]   = geo6_r.ab[k];
      y2_nxt[k]   = geo6_r.ac[k];
      base_nxt[k] = geo6_r.a[k];
    end
    if (dd_r[0] <= 0 && dd_r[1] <= 0) begin
      rg_nxt = RGN_A;
    end else if (dd_r[2] >= 0 && e1_r <= 0) begin
      rg_nxt = RGN_B;
      for (int k = 0; k < 3; k++) base_nxt[k] = geo6_r.b[k];
    end else if (dd_r[5] >= 0 && e2_r <= 0) begin
      rg_nxt = RGN_C;
      for (int k = 0; k < 3; k++) base_nxt[k] = geo6_r.c[k];
    end else if (vc6_r <= 0 && dd_r[0] >= 0 && dd_r[2] <= 0) begin
      rg_nxt  = RGN_AB;
      den_nxt = DENW'(e3_r);
      x1_nxt  = VW'(dd_r[0]);
      x2_nxt  = '0;
      for (int k = 0; k < 3; k++) begin
        y1_nxt[k] = geo6_r.ab[k];
        y2_nxt[k] = '0;
      end
    end else if (vb6_r <= 0 && dd_r[1] >= 0 && dd_r[5] <= 0) begin
      rg_nxt  = RGN_AC;
      den_nxt = DENW'(e4_r);
      x1_nxt  = VW'(dd_r[1]);
      x2_nxt  = '0;
      for (int k = 0; k < 3; k++) begin
        y1_nxt[k] = geo6_r.ac[k];
        y2_nxt[k] = '0;
      end
    end else if (va6_r <= 0 && e1_r >= 0 && e2_r >= 0) begin
      rg_nxt  = RGN_BC;
      den_nxt = DENW'(e5_r);
      x1_nxt  = VW'(e1_r);
      x2_nxt  = '0;
      for (int k = 0; k < 3; k++) begin
        y1_nxt[k]   = geo6_r.bc[k];
        y2_nxt[k]   = '0;
        base_nxt[k] = geo6_r.b[k];
      end
    end
  end

  logic                   v7_r;
  logic [2:0]             rg7_r;
  logic signed [DENW-1:0] den7_r;
  logic signed [VW-1:0]   x1_7_r, x2_7_r;
  logic signed [EW-1:0]   y1_7_r [3];
  logic signed [EW-1:0]   y2_7_r [3];
  logic signed [W-1:0]    base7_r [3];
  logic signed [W-1:0]    a7_r [3];

  always_ff @(posedge clk) begin
    rg7_r  <= rg_nxt;
    den7_r <= den_nxt;
    x1_7_r <= x1_nxt;
    x2_7_r <= x2_nxt;
    for (int k = 0; k < 3; k++) begin
      y1_7_r[k]  <= y1_nxt[k];
      y2_7_r[k]  <= y2_nxt[k];
      base7_r[k] <= base_nxt[k];
      a7_r[k]    <= geo6_r.a[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v6_r <= vl1_r[LM1-1];
      v7_r <= v6_r;
    end
  end

  // ---------------- numerator products: edge num*dir, interior vb*ab + vc*ac
  logic signed [MW2-1:0] m1 [3];
  logic signed [MW2-1:0] m2 [3];

  for (genvar k = 0; k < 3; k++) begin : g_num
    cpt_mul #(.AW(EW), .BW(VW)) u_n1 (
      .clk(clk), .op_a(y1_7_r[k]), .op_b(x1_7_r), .prod(m1[k])
    );
    cpt_mul #(.AW(EW), .BW(VW)) u_n2 (
      .clk(clk), .op_a(y2_7_r[k]), .op_b(x2_7_r), .prod(m2[k])
    );
  end

  side2_t         dl2_r [LM2];
  logic [LM2-1:0] vl2_r;
  side2_t         s2_in;

  always_comb begin
    s2_in.rg  = rg7_r;
    s2_in.den = den7_r;
    for (int k = 0; k < 3; k++) begin
      s2_in.base[k] = base7_r[k];
      s2_in.a[k]    = a7_r[k];
    end
  end

  always_ff @(posedge clk) begin
    dl2_r[0] <= s2_in;
    for (int i = 1; i < LM2; i++) begin
      dl2_r[i] <= dl2_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl2_r <= '0;
    end else begin
      vl2_r <= {vl2_r[LM2-2:0], v7_r};
    end
  end

  // ---------------- stage 8: numerator sum, zero divisor check
  logic                   v8_r;
  logic signed [NW-1:0]   n8_r [3];
  logic signed [DENW-1:0] den8_r;
  side3_t                 s8_r;
  side2_t                 s7d;

  assign s7d = dl2_r[LM2-1];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      n8_r[k] <= NW'(m1[k]) + NW'(m2[k]);
    end
    den8_r    <= s7d.den;
    s8_r.rg   <= s7d.rg;
    s8_r.deg  <= (s7d.den == '0) && (s7d.rg >= RGN_AB);
    s8_r.base <= s7d.base;
    s8_r.a    <= s7d.a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= vl2_r[LM2-1];
    end
  end

  // ---------------- dividers, one per axis
  logic signed [QB:0] quo [3];

  for (genvar k = 0; k < 3; k++) begin : g_div
    cpt_div #(.NW(NW), .DNW(DENW), .QB(QB)) u_div (
      .clk(clk), .num(n8_r[k]), .den(den8_r), .quo(quo[k])
    );
  end

  side3_t         dl3_r [LDV];
  logic [LDV-1:0] vl3_r;

  always_ff @(posedge clk) begin
    dl3_r[0] <= s8_r;
    for (int i = 1; i < LDV; i++) begin
      dl3_r[i] <= dl3_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl3_r <= '0;
    end else begin
      vl3_r <= {vl3_r[LDV-2:0], v8_r};
    end
  end

  // ---------------- output stage: add base, saturate
  side3_t              s9;
  logic signed [SW-1:0] sum [3];
  logic signed [W-1:0]  pt_nxt [3];

  assign s9 = dl3_r[LDV-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = SW'($signed(s9.base[k])) + SW'(quo[k]);
      if (s9.rg <= RGN_C) begin
        pt_nxt[k] = s9.base[k];
      end else if (s9.deg) begin
        pt_nxt[k] = s9.a[k];
      end else if (sum[k][SW-1:W-1] == '0 || sum[k][SW-1:W-1] == '1) begin
        pt_nxt[k] = sum[k][W-1:0];
      end else if (sum[k][SW-1]) begin
        pt_nxt[k] = {1'b1, {(W-1){1'b0}}};
      end else begin
        pt_nxt[k] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    out_near_x     <= pt_nxt[0];
    out_near_y     <= pt_nxt[1];
    out_near_z     <= pt_nxt[2];
    out_region     <= s9.rg;
    out_degenerate <= s9.deg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vl3_r[LDV-1];
    end
  end

  // ---------------- checks
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LATENCY out_valid)
    else $error("transaction result missing at fixed latency");

  a_rgn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_region <= RGN_IN)
    else $error("region code out of range");

  a_deg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_region >= RGN_AB)
    else $error("degenerate flag on a vertex region");

endmodule
